// ===== rtl/fpim_pkg.sv =====
// Shared types, constants and order table for the flash page interleave map.
`default_nettype none

package fpim_pkg;

    localparam int PAGE_WIDTH_DEF = 40;
    localparam int MAX_CHANNELS   = 16;
    localparam int MAX_CHIPS      = 16;
    localparam int MAX_DIES       = 8;
    localparam int MAX_PLANES     = 8;

    localparam int BITS_PER_STAGE = 8;
    localparam int DIGITS         = 4;
    localparam int CNT_W          = 5;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 5;
    localparam int ORDER_COUNT    = 24;

    typedef enum logic [1:0] {
        RES_C = 2'd0,
        RES_W = 2'd1,
        RES_D = 2'd2,
        RES_P = 2'd3
    } t_res;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORDER_SELECT  = 3'd0,
        CFG_CHANNEL_COUNT = 3'd1,
        CFG_CHIP_COUNT    = 3'd2,
        CFG_DIE_COUNT     = 3'd3,
        CFG_PLANE_COUNT   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [3:0] channel_index;
        logic [3:0] chip_index;
        logic [2:0] die_index;
        logic [2:0] plane_index;
    } t_result;

    // Each entry lists the resource of positions 3..0, two bits each, position 0 fastest.
    localparam logic [7:0] ORDER_TABLE [ORDER_COUNT] = '{
        8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
        8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
        8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
        8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
    };

    function automatic t_res order_res(input logic [4:0] sel, input logic [1:0] pos);
        logic [4:0] s;
        logic [7:0] entry;
        s     = (int'(sel) < ORDER_COUNT) ? sel : 5'd0;
        entry = ORDER_TABLE[s];
        return t_res'(entry[2*pos +: 2]);
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int maxv);
        if (v == '0) begin
            return CNT_W'(1);
        end
        if (int'(v) > maxv) begin
            return CNT_W'(maxv);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fpim_div_stage.sv =====
// One pipeline stage of a digit division: several restoring steps by a small divisor.
`default_nettype none

module fpim_div_stage
    import fpim_pkg::*;
#(
    parameter int WORD_W = PAGE_WIDTH_DEF,
    parameter int HI     = WORD_W - 1,
    parameter int LO     = 0,
    parameter bit LAST   = 1'b0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [CNT_W-1:0]  i_rem,
    input  wire t_result           i_result,
    input  wire logic [CNT_W-1:0]  i_divisor,
    input  wire t_res              i_res,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_word,
    output logic [CNT_W-1:0]       o_rem,
    output t_result                o_result
);

    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_rem;
    t_result           r_result;

    logic [WORD_W-1:0] n_word;
    logic [CNT_W-1:0]  n_rem;
    t_result           n_result;

    always_comb begin
        logic [CNT_W-1:0] rem;
        logic [CNT_W:0]   t;
        n_word   = i_word;
        rem      = i_rem;
        n_result = i_result;
        for (int b = HI; b >= LO; b--) begin
            t = {rem, n_word[b]};
            if (t >= {1'b0, i_divisor}) begin
                rem       = CNT_W'(t - {1'b0, i_divisor});
                n_word[b] = 1'b1;
            end else begin
                rem       = t[CNT_W-1:0];
                n_word[b] = 1'b0;
            end
        end
        if (LAST) begin
            n_rem = '0;
            unique case (i_res)
                RES_C: n_result.channel_index = rem[3:0];
                RES_W: n_result.chip_index    = rem[3:0];
                RES_D: n_result.die_index     = rem[2:0];
                RES_P: n_result.plane_index   = rem[2:0];
            endcase
        end else begin
            n_rem = rem;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word   <= n_word;
            r_rem    <= n_rem;
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_rem    = r_rem;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/flash_page_interleave_map.sv =====
// Top level of the flash page interleave map: configuration registers and division pipeline.
//
// A page number is split into channel, chip, die and plane indices as a mixed-radix
// number whose digit order is chosen by order_select, fastest digit first. The block
// takes one item per cycle while its output side takes items: the four digits are extracted
// one after another by restoring division with the configured counts, eight quotient bits per
// pipeline stage. Every stage holds its item while the output is stalled and closes up
// bubbles, so input ready only drops when the whole pipeline is full. Counts of zero act as
// one and counts above the supported maximum saturate; die and plane counts keep only the
// low four bits of the written value. Order codes above 23 act as order 0.
// Configuration is written through a plain write port and must only change while the
// pipeline is empty.
`default_nettype none

module flash_page_interleave_map
    import fpim_pkg::*;
#(
    parameter int PAGE_WIDTH = PAGE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [PAGE_WIDTH-1:0] i_page_number,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [3:0]                 o_channel_index,
    output logic [3:0]                 o_chip_index,
    output logic [2:0]                 o_die_index,
    output logic [2:0]                 o_plane_index
);

    localparam int NSTG = (PAGE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int NS   = DIGITS * NSTG;

    logic [4:0] r_order_select;
    logic [4:0] r_channel_count;
    logic [4:0] r_chip_count;
    logic [3:0] r_die_count;
    logic [3:0] r_plane_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_select  <= 5'd0;
            r_channel_count <= 5'd1;
            r_chip_count    <= 5'd1;
            r_die_count     <= 4'd1;
            r_plane_count   <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_ORDER_SELECT:  r_order_select  <= i_cfg_wdata[4:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[4:0];
                CFG_CHIP_COUNT:    r_chip_count    <= i_cfg_wdata[4:0];
                CFG_DIE_COUNT:     r_die_count     <= i_cfg_wdata[3:0];
                CFG_PLANE_COUNT:   r_plane_count   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    t_res             pos_res [DIGITS];
    logic [CNT_W-1:0] pos_div [DIGITS];

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            pos_res[k] = order_res(r_order_select, 2'(k));
            case (pos_res[k])
                RES_C:   pos_div[k] = clamp_count(r_channel_count, MAX_CHANNELS);
                RES_W:   pos_div[k] = clamp_count(r_chip_count, MAX_CHIPS);
                RES_D:   pos_div[k] = clamp_count({1'b0, r_die_count}, MAX_DIES);
                default: pos_div[k] = clamp_count({1'b0, r_plane_count}, MAX_PLANES);
            endcase
        end
    end

    logic                  s_valid  [NS+1];
    logic                  s_ready  [NS+1];
    logic [PAGE_WIDTH-1:0] s_word   [NS+1];
    logic [CNT_W-1:0]      s_rem    [NS+1];
    t_result               s_result [NS+1];

    assign s_valid[0]  = i_valid;
    assign o_ready     = s_ready[0];
    assign s_word[0]   = i_page_number;
    assign s_rem[0]    = '0;
    assign s_result[0] = '0;

    for (genvar k = 0; k < DIGITS; k++) begin : g_digit
        for (genvar j = 0; j < NSTG; j++) begin : g_stage
            localparam int S    = k * NSTG + j;
            localparam int HI_B = PAGE_WIDTH - 1 - j * BITS_PER_STAGE;
            localparam int LO_B = (HI_B >= BITS_PER_STAGE - 1) ?
                                  HI_B - BITS_PER_STAGE + 1 : 0;

            fpim_div_stage #(
                .WORD_W (PAGE_WIDTH),
                .HI     (HI_B),
                .LO     (LO_B),
                .LAST   (j == NSTG - 1)
            ) u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (s_valid[S]),
                .o_ready   (s_ready[S]),
                .i_word    (s_word[S]),
                .i_rem     (s_rem[S]),
                .i_result  (s_result[S]),
                .i_divisor (pos_div[k]),
                .i_res     (pos_res[k]),
                .o_valid   (s_valid[S+1]),
                .i_ready   (s_ready[S+1]),
                .o_word    (s_word[S+1]),
                .o_rem     (s_rem[S+1]),
                .o_result  (s_result[S+1])
            );
        end
    end

    assign s_ready[NS]     = i_ready;
    assign o_valid         = s_valid[NS];
    assign o_channel_index = s_result[NS].channel_index;
    assign o_chip_index    = s_result[NS].chip_index;
    assign o_die_index     = s_result[NS].die_index;
    assign o_plane_index   = s_result[NS].plane_index;

endmodule

`default_nettype wire

// ===== rtl/fpim_checker.sv =====
// Port-level assertions for the flash page interleave map and their bind.
`default_nettype none

module fpim_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [3:0] o_channel_index,
    input wire logic [3:0] o_chip_index,
    input wire logic [2:0] o_die_index,
    input wire logic [2:0] o_plane_index
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_channel_index) &&
        $stable(o_chip_index) && $stable(o_die_index) && $stable(o_plane_index))
        else $error("Stalled result item changed or vanished.");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("Input stalled although the output side takes items.");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input stalled although the last stage is empty.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("Pipeline not empty after reset.");

endmodule

bind flash_page_interleave_map fpim_checker u_fpim_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_channel_index (o_channel_index),
    .o_chip_index    (o_chip_index),
    .o_die_index     (o_die_index),
    .o_plane_index   (o_plane_index)
);

`default_nettype wire

// ===== dv/tb_flash_page_interleave_map.sv =====
// Self-checking testbench for flash_page_interleave_map with directed and random page mapping.
`timescale 1ns / 1ps

module tb_flash_page_interleave_map
    import fpim_pkg::*;
();

    localparam int PAGE_W          = PAGE_WIDTH_DEF;
    localparam int PIPE_LATENCY    = 4 * ((PAGE_W + 7) / 8);
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int LIMIT_CYCLES    = 200000;

    localparam logic [CFG_DATA_W-1:0] ORDER_CWDP        = 5'd0;
    localparam logic [CFG_DATA_W-1:0] ORDER_CDPW        = 5'd3;
    localparam logic [CFG_DATA_W-1:0] ORDER_WPDC        = 5'd11;
    localparam logic [CFG_DATA_W-1:0] ORDER_PDWC        = 5'd23;
    localparam logic [CFG_DATA_W-1:0] ORDER_UNKNOWN_LO  = 5'd24;
    localparam logic [CFG_DATA_W-1:0] ORDER_UNKNOWN_HI  = 5'd31;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_FIRST   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LAST    = 3'd7;
    localparam logic [PAGE_W-1:0]     PAGE_ALL_ONES     = '1;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [PAGE_W-1:0]     page;
        logic                  typed;
        t_result               want;
    } t_dir_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [PAGE_W-1:0]     i_page_number;
    logic                  o_valid;
    logic                  i_ready;
    logic [3:0]            o_channel_index;
    logic [3:0]            o_chip_index;
    logic [2:0]            o_die_index;
    logic [2:0]            o_plane_index;

    logic [4:0] cfg_order;
    logic [4:0] cfg_channels;
    logic [4:0] cfg_chips;
    logic [3:0] cfg_dies;
    logic [3:0] cfg_planes;

    t_result   pending_maps [$];
    t_result   head_map;
    t_dir_step directed_steps [$];
    int        mismatches;
    int        cycles;
    int        hold_requests;
    int        hold_served;
    int        stall_left;
    bit        gaps_on;
    bit        stalls_on;
    bit        cfg_open;

    flash_page_interleave_map #(
        .PAGE_WIDTH(PAGE_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_page_number  (i_page_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channel_index(o_channel_index),
        .o_chip_index   (o_chip_index),
        .o_die_index    (o_die_index),
        .o_plane_index  (o_plane_index)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] eff_count(input logic [4:0] v, input int maxv);
        if (v == '0) begin
            return 64'd1;
        end
        if (int'(v) > maxv) begin
            return 64'(maxv);
        end
        return 64'(v);
    endfunction

    // Orders are the permutations of C, W, D, P in lexicographic order, so the order code
    // is read as a factorial-base number that picks each digit from the unused resources.
    function automatic t_result map_page(input logic [PAGE_W-1:0] page);
        logic [63:0] radix [4];
        logic [63:0] digit [4];
        logic [63:0] stride;
        int          code;
        int          rank [3];
        int          skip;
        int          pick;
        logic [3:0]  taken;
        t_result     r;
        radix[RES_C] = eff_count(cfg_channels, MAX_CHANNELS);
        radix[RES_W] = eff_count(cfg_chips, MAX_CHIPS);
        radix[RES_D] = eff_count({1'b0, cfg_dies}, MAX_DIES);
        radix[RES_P] = eff_count({1'b0, cfg_planes}, MAX_PLANES);
        code = (int'(cfg_order) < ORDER_COUNT) ? int'(cfg_order) : int'(ORDER_CWDP);
        rank[0] = code / 6;
        rank[1] = (code % 6) / 2;
        rank[2] = code % 2;
        taken = '0;
        stride = 64'd1;
        for (int pos = 0; pos < 4; pos++) begin
            skip = (pos < 3) ? rank[pos] : 0;
            pick = 0;
            for (int k = 0; k < 4; k++) begin
                if (!taken[k]) begin
                    if (skip == 0) begin
                        pick = k;
                    end
                    skip--;
                end
            end
            taken[pick] = 1'b1;
            digit[pick] = (64'(page) / stride) % radix[pick];
            stride = stride * radix[pick];
        end
        r.channel_index = digit[RES_C][3:0];
        r.chip_index    = digit[RES_W][3:0];
        r.die_index     = digit[RES_D][2:0];
        r.plane_index   = digit[RES_P][2:0];
        return r;
    endfunction

    function automatic t_dir_step cfg_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_dir_step s;
        s = '{1'b1, idx, val, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic t_dir_step page_row(input logic [PAGE_W-1:0] page);
        t_dir_step s;
        s = '{1'b0, '0, '0, page, 1'b0, '0};
        return s;
    endfunction

    function automatic t_dir_step known_row(input logic [PAGE_W-1:0] page, input int ch,
                                            input int chip, input int die, input int plane);
        t_dir_step s;
        t_result   w;
        w = '{4'(ch), 4'(chip), 3'(die), 3'(plane)};
        s = '{1'b0, '0, '0, page, 1'b1, w};
        return s;
    endfunction

    function automatic logic [PAGE_W-1:0] rand_page();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return '0;
        end
        if (sel == 1) begin
            return PAGE_ALL_ONES;
        end
        if (sel < 4) begin
            return PAGE_W'($urandom_range(0, 4095));
        end
        return PAGE_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_count(input int maxv);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return '0;
        end
        if (sel == 1) begin
            return CFG_DATA_W'($urandom_range(maxv + 1, 31));
        end
        return CFG_DATA_W'($urandom_range(1, maxv));
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ORDER_SELECT:  cfg_order    = val;
            CFG_CHANNEL_COUNT: cfg_channels = val;
            CFG_CHIP_COUNT:    cfg_chips    = val;
            CFG_DIE_COUNT:     cfg_dies     = val[3:0];
            CFG_PLANE_COUNT:   cfg_planes   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_maps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_page(input logic [PAGE_W-1:0] page, input logic typed,
                             input t_result want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (!o_ready);
        pending_maps.push_back(typed ? want : map_page(page));
    endtask

    always @(posedge i_clk) begin
        if (hold_served < hold_requests) begin
            hold_served++;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("flash_page_interleave_map test failed");
            $finish;
        end else if (i_rst_n && o_valid && i_ready) begin
            if (pending_maps.size() == 0) begin
                note_mismatch("unexpected item, channel_index", -1, o_channel_index);
            end else begin
                head_map = pending_maps.pop_front();
                if (o_channel_index !== head_map.channel_index) begin
                    note_mismatch("channel_index", head_map.channel_index, o_channel_index);
                end
                if (o_chip_index !== head_map.chip_index) begin
                    note_mismatch("chip_index", head_map.chip_index, o_chip_index);
                end
                if (o_die_index !== head_map.die_index) begin
                    note_mismatch("die_index", head_map.die_index, o_die_index);
                end
                if (o_plane_index !== head_map.plane_index) begin
                    note_mismatch("plane_index", head_map.plane_index, o_plane_index);
                end
            end
        end
    end

    initial begin
        int n_items;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_page_number = '0;
        i_ready       = 1'b0;
        cfg_order     = ORDER_CWDP;
        cfg_channels  = 5'd1;
        cfg_chips     = 5'd1;
        cfg_dies      = 4'd1;
        cfg_planes    = 4'd1;
        mismatches    = 0;
        cycles        = 0;
        hold_requests = 0;
        hold_served   = 0;
        stall_left    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        cfg_open      = 1'b0;

        directed_steps = '{
            known_row('0, 0, 0, 0, 0),
            known_row(PAGE_ALL_ONES, 0, 0, 0, 0),
            cfg_row(CFG_CHANNEL_COUNT, 5'd16),
            cfg_row(CFG_CHIP_COUNT, 5'd16),
            cfg_row(CFG_DIE_COUNT, 5'd8),
            cfg_row(CFG_PLANE_COUNT, 5'd8),
            known_row('0, 0, 0, 0, 0),
            known_row(PAGE_ALL_ONES, 15, 15, 7, 7),
            page_row(40'h80_0000_0001),
            page_row(40'h12_3456_789A),
            cfg_row(CFG_ORDER_SELECT, ORDER_PDWC),
            known_row(40'd5, 0, 0, 0, 5),
            known_row(PAGE_ALL_ONES, 15, 15, 7, 7),
            page_row(40'h00_0000_1234),
            cfg_row(CFG_ORDER_SELECT, ORDER_UNKNOWN_LO),
            known_row(40'd5, 5, 0, 0, 0),
            cfg_row(CFG_ORDER_SELECT, ORDER_UNKNOWN_HI),
            known_row(40'd19, 3, 1, 0, 0),
            cfg_row(CFG_ORDER_SELECT, ORDER_CWDP),
            cfg_row(CFG_CHANNEL_COUNT, 5'd0),
            cfg_row(CFG_CHIP_COUNT, 5'd31),
            cfg_row(CFG_DIE_COUNT, 5'h1F),
            cfg_row(CFG_PLANE_COUNT, 5'd0),
            known_row(40'd37, 0, 5, 2, 0),
            cfg_row(CFG_ORDER_SELECT, ORDER_CDPW),
            cfg_row(CFG_CHANNEL_COUNT, 5'd17),
            cfg_row(CFG_CHIP_COUNT, 5'd3),
            cfg_row(CFG_DIE_COUNT, 5'd9),
            cfg_row(CFG_PLANE_COUNT, 5'h10),
            known_row(40'd200, 8, 1, 4, 0),
            cfg_row(CFG_SPARE_FIRST, 5'h1F),
            cfg_row(CFG_SPARE_LAST, 5'h1F),
            known_row(PAGE_ALL_ONES, 15, 1, 7, 0),
            cfg_row(CFG_ORDER_SELECT, ORDER_WPDC),
            cfg_row(CFG_CHANNEL_COUNT, 5'd5),
            cfg_row(CFG_CHIP_COUNT, 5'd7),
            cfg_row(CFG_DIE_COUNT, 5'd6),
            cfg_row(CFG_PLANE_COUNT, 5'd3),
            page_row(PAGE_ALL_ONES),
            page_row(40'd12345),
            page_row(40'd1)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                if (!cfg_open) begin
                    wait_drained();
                    cfg_open = 1'b1;
                end
                write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_page(directed_steps[i].page, directed_steps[i].typed,
                          directed_steps[i].want);
            end
        end

        // The final two phases run with both sides at full rate.
        for (int phase = 0; phase < 12; phase++) begin
            wait_drained();
            gaps_on   = (phase < 10);
            stalls_on = (phase < 10);
            write_reg(CFG_ORDER_SELECT, ($urandom_range(0, 7) == 0) ?
                      CFG_DATA_W'($urandom_range(ORDER_UNKNOWN_LO, ORDER_UNKNOWN_HI)) :
                      CFG_DATA_W'($urandom_range(ORDER_CWDP, ORDER_PDWC)));
            write_reg(CFG_CHANNEL_COUNT, rand_count(MAX_CHANNELS));
            write_reg(CFG_CHIP_COUNT, rand_count(MAX_CHIPS));
            write_reg(CFG_DIE_COUNT, rand_count(MAX_DIES));
            write_reg(CFG_PLANE_COUNT, rand_count(MAX_PLANES));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_ADDR_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          CFG_DATA_W'($urandom));
            end
            i_cfg_we <= 1'b0;
            if (phase == 2) begin
                hold_requests++;
            end
            n_items = $urandom_range(28, 36);
            for (int k = 0; k < n_items; k++) begin
                if (phase == 5 && k == n_items / 2) begin
                    wait_drained();
                end
                send_page(rand_page(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatches == 0 && pending_maps.size() == 0) begin
            $display("flash_page_interleave_map test passed");
        end else begin
            $display("flash_page_interleave_map test failed");
        end
        $finish;
    end

endmodule
